### design/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg: shared types and constants of the frame deframer
// Holds the result record passed from the parser to the output register.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  localparam logic [3:0] CloseOpcode = 4'h8;
  localparam logic [6:0] LenExt16    = 7'd126;
  localparam logic [6:0] LenExt64    = 7'd127;
  localparam logic [3:0] Ext16Bytes  = 4'd2;
  localparam logic [3:0] Ext64Bytes  = 4'd8;
  localparam logic [3:0] MaskBytes   = 4'd4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        data_valid;
    logic [3:0]  frame_opcode;
    logic        final_fragment;
    logic        frame_end;
    logic [15:0] close_code;
    logic        close_code_valid;
    logic        truncated;
  } wsfd_result_t;

endpackage

### design/wsfd_parser.sv
// ----------------------------------------------------------------------------
// wsfd_parser: frame header and payload parser
// Holds the parse state and forms the result for one byte in a single pass.
// ----------------------------------------------------------------------------
module wsfd_parser #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  output logic                  emit_o,
  output wsfd_pkg::wsfd_result_t result_o
);

  typedef enum logic [2:0] {
    PhHdr0,
    PhHdr1,
    PhExt,
    PhMask,
    PhPayload,
    PhDrop
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [3:0]             cnt_q, cnt_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [LENGTH_BITS-1:0] idx_q, idx_d;
  logic [31:0]            key_q, key_d;
  logic                   masked_q, masked_d;
  logic [3:0]             opcode_q, opcode_d;
  logic                   fin_q, fin_d;
  logic [15:0]            close_q, close_d;

  logic       active, done, trunc, dv, fe, cv;
  logic [7:0] db, kb;
  logic [6:0] l7;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    idx_d    = idx_q;
    key_d    = key_q;
    masked_d = masked_q;
    opcode_d = opcode_q;
    fin_d    = fin_q;
    close_d  = close_q;
    active   = 1'b1;
    done     = 1'b0;
    trunc    = 1'b0;
    dv       = 1'b0;
    db       = 8'h00;
    kb       = 8'h00;
    l7       = byte_i[6:0];
    emit_o   = 1'b0;

    case (phase_q)
      PhHdr0: begin
        fin_d    = byte_i[7];
        opcode_d = byte_i[3:0];
        masked_d = 1'b0;
        len_d    = '0;
        idx_d    = '0;
        key_d    = '0;
        close_d  = '0;
        cnt_d    = '0;
        phase_d  = PhHdr1;
      end
      PhHdr1: begin
        masked_d = byte_i[7];
        if (l7 == wsfd_pkg::LenExt16) begin
          cnt_d   = wsfd_pkg::Ext16Bytes;
          phase_d = PhExt;
        end else if (l7 == wsfd_pkg::LenExt64) begin
          cnt_d   = wsfd_pkg::Ext64Bytes;
          phase_d = PhExt;
        end else begin
          len_d = LENGTH_BITS'(l7);
          if (byte_i[7]) begin
            cnt_d   = wsfd_pkg::MaskBytes;
            phase_d = PhMask;
          end else if (l7 == 7'd0) begin
            done = 1'b1;
          end else begin
            phase_d = PhPayload;
          end
        end
      end
      PhExt: begin
        // saturate once the top byte would be shifted out
        if (len_q[LENGTH_BITS-1 -: 8] != 8'h00) begin
          len_d = '1;
        end else begin
          len_d = {len_q[LENGTH_BITS-9:0], byte_i};
        end
        cnt_d = cnt_q - 4'd1;
        if (cnt_d == 4'd0) begin
          if (masked_q) begin
            cnt_d   = wsfd_pkg::MaskBytes;
            phase_d = PhMask;
          end else if (len_d == '0) begin
            done = 1'b1;
          end else begin
            phase_d = PhPayload;
          end
        end
      end
      PhMask: begin
        key_d = {key_q[23:0], byte_i};
        cnt_d = cnt_q - 4'd1;
        if (cnt_d == 4'd0) begin
          if (len_q == '0) begin
            done = 1'b1;
          end else begin
            phase_d = PhPayload;
          end
        end
      end
      PhPayload: begin
        case (idx_q[1:0])
          2'd0:    kb = key_q[31:24];
          2'd1:    kb = key_q[23:16];
          2'd2:    kb = key_q[15:8];
          default: kb = key_q[7:0];
        endcase
        db = masked_q ? (byte_i ^ kb) : byte_i;
        if (idx_q == '0) begin
          close_d[15:8] = db;
        end else if (idx_q == LENGTH_BITS'(1)) begin
          close_d[7:0] = db;
        end
        idx_d  = idx_q + LENGTH_BITS'(1);
        dv     = 1'b1;
        emit_o = 1'b1;
        done   = (idx_d >= len_q);
      end
      PhDrop: begin
        active = 1'b0;
        if (last_i) begin
          phase_d = PhHdr0;
        end
      end
      default: begin
        active  = 1'b0;
        phase_d = PhHdr0;
      end
    endcase

    if (active) begin
      if (done) begin
        emit_o  = 1'b1;
        phase_d = last_i ? PhHdr0 : PhDrop;
      end else if (last_i) begin
        emit_o  = 1'b1;
        trunc   = 1'b1;
        phase_d = PhHdr0;
      end
    end

    fe = done | trunc;
    cv = fe && (opcode_d == wsfd_pkg::CloseOpcode) && (idx_d >= LENGTH_BITS'(2));

    result_o.data_byte        = dv ? db : 8'h00;
    result_o.data_valid       = dv;
    result_o.frame_opcode     = opcode_d;
    result_o.final_fragment   = fin_d;
    result_o.frame_end        = fe;
    result_o.close_code       = cv ? close_d : 16'h0000;
    result_o.close_code_valid = cv;
    result_o.truncated        = trunc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdr0;
      cnt_q    <= '0;
      len_q    <= '0;
      idx_q    <= '0;
      key_q    <= '0;
      masked_q <= 1'b0;
      opcode_q <= '0;
      fin_q    <= 1'b0;
      close_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      key_q    <= key_d;
      masked_q <= masked_d;
      opcode_q <= opcode_d;
      fin_q    <= fin_d;
      close_q  <= close_d;
    end
  end

endmodule

### design/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer: receive-side frame parser
// Datapath: a byte beat is held in the input register; the result that the
// parser forms from it in a single pass is held in the result register.
// Throughput: one byte beat per cycle unless the result register is stalled.
// Reset: asynchronous, active low; parsing restarts at the first header byte
// and both registers come up empty.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,   // buffer_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] data_byte, [8] data_valid, [12:9] frame_opcode, [13] final_fragment,
  // [29:14] close_code, [30] close_code_valid, [31] zero
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,   // frame_end
  output logic        m_axis_tuser_o    // truncated
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // result register
  logic                  out_valid_q, out_valid_d;
  wsfd_pkg::wsfd_result_t out_q;

  logic                  accept, advance, emit;
  wsfd_pkg::wsfd_result_t result;

  // Advance the held beat whenever the result register is free or draining.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  wsfd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .emit_o  (emit),
    .result_o(result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    // Load a result when the parser emits one; drop the old one once taken.
    out_valid_d = out_valid_q;
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (advance && emit) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.close_code_valid, out_q.close_code,
                            out_q.final_fragment, out_q.frame_opcode,
                            out_q.data_valid, out_q.data_byte};
  assign m_axis_tlast_o  = out_q.frame_end;
  assign m_axis_tuser_o  = out_q.truncated;

  // A result without a payload byte always closes its frame.
  a_nodata_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !out_q.data_valid |-> out_q.frame_end)
    else $error("result without payload byte does not end a frame");

  // Truncation and close codes only appear on the last result of a frame.
  a_trunc_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (out_q.truncated || out_q.close_code_valid) |-> out_q.frame_end)
    else $error("truncated or close code flagged before frame end");

  // A held beat that cannot advance stays held.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q))
    else $error("held input beat lost while stalled");

  // A stalled result must not be overwritten.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |-> !advance)
    else $error("parser advanced into a stalled result register");

endmodule
